// ===== rtl/plt_pkg.sv =====
// ============================================================================
// plt_pkg
// Shared types and constants for the positional list table unit.
// ============================================================================
package plt_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int CMD_W = 3;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd4;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_LD_TOP,
        PTR_LD_POS,
        PTR_LD_ZERO,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SHIFT,
        S_INS_LAST,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_CAP,
        S_DEL_SHIFT,
        S_DEL_END,
        S_GET_RD,
        S_GET_CAP,
        S_LOC_SCAN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    cap;
        t_ptr_op ptr_op;
        logic    rd_en;
        logic    rd_copy;
        logic    copy_up;
        logic    wr_val;
        logic    ld_rd;
        logic    ld_idx;
        logic    clr_out;
        logic    res;
        t_status res_status;
        t_cnt_op cnt_op;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             ins_bad;
        logic             acc_bad;
        logic             empty;
        logic             append;
        logic             at_first;
        logic             at_end;
        logic             match;
    } t_dp_stat;

endpackage

// ===== rtl/plt_datapath.sv =====
// ============================================================================
// plt_datapath
// Entry store, length count, walk pointer, copy pipeline and result registers.
// ============================================================================
module plt_datapath
    import plt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    input  t_dp_cmd                 i_ctl,
    output t_dp_stat                o_stat,
    output logic                    o_valid,
    output logic [2:0]              o_status,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic [IDX_W-1:0]        o_found_index,
    output logic [CNT_W-1:0]        o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [VAL_W-1:0] mem [DEPTH];

    logic [CMD_W-1:0]        r_cmd;
    logic [POS_W-1:0]        r_pos;
    logic [VAL_W-1:0]        r_val;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_ptr, n_ptr;
    logic [AW-1:0]           r_wa;
    logic                    r_pend;
    logic [VAL_W-1:0]        r_rdata;
    logic [AW-1:0]           r_ra;
    logic                    r_rd_vld;
    logic [VAL_W-1:0]        r_out_rd;
    logic [IDX_W-1:0]        r_out_idx;
    t_status                 r_status;
    logic                    r_valid;

    logic [PW-1:0] pos_x, cnt_x, ptr_x, pos_m1x;

    assign pos_x   = PW'(r_pos);
    assign cnt_x   = PW'(r_count);
    assign ptr_x   = PW'(r_ptr);
    assign pos_m1x = pos_x - PW'(1);

    always_comb begin
        o_stat.cmd      = r_cmd;
        o_stat.full     = (r_count == CW'(DEPTH));
        o_stat.ins_bad  = (pos_x == '0) || (pos_x > cnt_x + PW'(1));
        o_stat.acc_bad  = (pos_x == '0) || (pos_x > cnt_x);
        o_stat.empty    = (r_count == '0);
        o_stat.append   = (pos_x == cnt_x + PW'(1));
        o_stat.at_first = (ptr_x + PW'(1) == pos_x);
        o_stat.at_end   = (r_ptr == r_count);
        o_stat.match    = r_rd_vld && (r_rdata == r_val);
    end

    always_comb begin
        case (i_ctl.ptr_op)
            PTR_LD_TOP:  n_ptr = r_count - CW'(1);
            PTR_LD_POS:  n_ptr = CW'(pos_m1x);
            PTR_LD_ZERO: n_ptr = '0;
            PTR_INC:     n_ptr = r_ptr + CW'(1);
            PTR_DEC:     n_ptr = r_ptr - CW'(1);
            default:     n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        case (i_ctl.cnt_op)
            CNT_CLR: n_count = '0;
            CNT_INC: n_count = r_count + CW'(1);
            CNT_DEC: n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    // store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            mem[r_wa] <= r_rdata;
        end else if (i_ctl.wr_val) begin
            mem[pos_m1x[AW-1:0]] <= r_val;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= mem[r_ptr[AW-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_pend   <= i_ctl.rd_en && i_ctl.rd_copy;
            r_rd_vld <= i_ctl.rd_en;
            r_valid  <= i_ctl.res;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_ra  <= r_ptr[AW-1:0];
        r_wa  <= i_ctl.copy_up ? r_ptr[AW-1:0] + AW'(1) : r_ptr[AW-1:0] - AW'(1);
        if (i_ctl.cap) begin
            r_cmd <= i_cmd;
            r_pos <= i_position;
            r_val <= i_value;
        end
        if (i_ctl.clr_out) begin
            r_out_rd  <= '0;
            r_out_idx <= '0;
        end
        if (i_ctl.ld_rd) begin
            r_out_rd <= r_rdata;
        end
        if (i_ctl.ld_idx) begin
            r_out_idx <= IDX_W'(r_ra);
        end
        if (i_ctl.res) begin
            r_status <= i_ctl.res_status;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_read_value  = r_out_rd;
    assign o_found_index = r_out_idx;
    assign o_count       = CNT_W'(r_count);

endmodule

// ===== rtl/plt_ctrl.sv =====
// ============================================================================
// plt_ctrl
// Sequencer: decodes a request and steps the datapath through its walk.
// ============================================================================
module plt_ctrl
    import plt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_ctl,
    output logic     o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_busy  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                o_ctl.clr_out = 1'b1;
                unique case (i_stat.cmd)
                    CMD_CLEAR: begin
                        o_ctl.res    = 1'b1;
                        o_ctl.cnt_op = CNT_CLR;
                        n_state      = S_IDLE;
                    end
                    CMD_INSERT: begin
                        if (i_stat.full) begin
                            o_ctl.res        = 1'b1;
                            o_ctl.res_status = ST_FULL;
                            n_state          = S_IDLE;
                        end else if (i_stat.ins_bad) begin
                            o_ctl.res        = 1'b1;
                            o_ctl.res_status = ST_BADPOS;
                            n_state          = S_IDLE;
                        end else if (i_stat.append) begin
                            n_state = S_INS_PUT;
                        end else begin
                            o_ctl.ptr_op = PTR_LD_TOP;
                            n_state      = S_INS_SHIFT;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_stat.empty) begin
                            o_ctl.res        = 1'b1;
                            o_ctl.res_status = ST_EMPTY;
                            n_state          = S_IDLE;
                        end else if (i_stat.acc_bad) begin
                            o_ctl.res        = 1'b1;
                            o_ctl.res_status = ST_BADPOS;
                            n_state          = S_IDLE;
                        end else begin
                            o_ctl.ptr_op = PTR_LD_POS;
                            n_state      = S_DEL_RD;
                        end
                    end
                    CMD_GET: begin
                        if (i_stat.acc_bad) begin
                            o_ctl.res        = 1'b1;
                            o_ctl.res_status = ST_BADPOS;
                            n_state          = S_IDLE;
                        end else begin
                            o_ctl.ptr_op = PTR_LD_POS;
                            n_state      = S_GET_RD;
                        end
                    end
                    CMD_LOCATE: begin
                        if (i_stat.empty) begin
                            o_ctl.res        = 1'b1;
                            o_ctl.res_status = ST_NOTFOUND;
                            n_state          = S_IDLE;
                        end else begin
                            o_ctl.ptr_op = PTR_LD_ZERO;
                            n_state      = S_LOC_SCAN;
                        end
                    end
                    default: begin
                        // unused codes: no change
                        o_ctl.res = 1'b1;
                        n_state   = S_IDLE;
                    end
                endcase
            end
            S_INS_SHIFT: begin
                // copy entry at ptr up by one, top first
                o_ctl.rd_en   = 1'b1;
                o_ctl.rd_copy = 1'b1;
                o_ctl.copy_up = 1'b1;
                if (i_stat.at_first) begin
                    n_state = S_INS_LAST;
                end else begin
                    o_ctl.ptr_op = PTR_DEC;
                end
            end
            S_INS_LAST: begin
                n_state = S_INS_PUT;
            end
            S_INS_PUT: begin
                o_ctl.wr_val = 1'b1;
                o_ctl.cnt_op = CNT_INC;
                o_ctl.res    = 1'b1;
                n_state      = S_IDLE;
            end
            S_DEL_RD: begin
                o_ctl.rd_en  = 1'b1;
                o_ctl.ptr_op = PTR_INC;
                n_state      = S_DEL_CAP;
            end
            S_DEL_CAP: begin
                o_ctl.ld_rd = 1'b1;
                if (i_stat.at_end) begin
                    n_state = S_DEL_END;
                end else begin
                    o_ctl.rd_en   = 1'b1;
                    o_ctl.rd_copy = 1'b1;
                    o_ctl.ptr_op  = PTR_INC;
                    n_state       = S_DEL_SHIFT;
                end
            end
            S_DEL_SHIFT: begin
                if (i_stat.at_end) begin
                    n_state = S_DEL_END;
                end else begin
                    o_ctl.rd_en   = 1'b1;
                    o_ctl.rd_copy = 1'b1;
                    o_ctl.ptr_op  = PTR_INC;
                end
            end
            S_DEL_END: begin
                o_ctl.cnt_op = CNT_DEC;
                o_ctl.res    = 1'b1;
                n_state      = S_IDLE;
            end
            S_GET_RD: begin
                o_ctl.rd_en = 1'b1;
                n_state     = S_GET_CAP;
            end
            S_GET_CAP: begin
                o_ctl.ld_rd = 1'b1;
                o_ctl.res   = 1'b1;
                n_state     = S_IDLE;
            end
            S_LOC_SCAN: begin
                if (i_stat.match) begin
                    o_ctl.ld_idx = 1'b1;
                    o_ctl.res    = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_stat.at_end) begin
                    o_ctl.res        = 1'b1;
                    o_ctl.res_status = ST_NOTFOUND;
                    n_state          = S_IDLE;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.ptr_op = PTR_INC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/positional_list_table_unit.sv =====
// ============================================================================
// positional_list_table_unit
// Ordered list of up to DEPTH signed words with clear, insert, delete, get, locate.
// ============================================================================
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+-------------------
//  request  | i_cmd, i_position, i_value                   | start && !busy
//  result   | o_status, o_read_value, o_found_index,       | o_valid, one cycle
//           | o_count                                      |
//
//  Clear, rejected requests and unused codes finish straight from decode;
//  get reads one entry; insert and delete walk the entries between position
//  p and the end of the list (an append skips the walk); locate scans from
//  the front until a match or the end of the list.
//  The walk moves one entry per cycle through the store's single write
//  port and registered read port; a copy is read one cycle, written the next.
//  busy is high from accept until the result strobe; the result strobe
//  lands in the cycle busy drops, so a new request can be taken at once.
//  Reset (synchronous, active low) empties the list; entry contents are
//  not cleared. The receiver cannot stall: each result shows for one cycle.
//
module positional_list_table_unit
    import plt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_valid,
    output logic [2:0]              o_status,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic [IDX_W-1:0]        o_found_index,
    output logic [CNT_W-1:0]        o_count
);

    t_dp_cmd  ctl;
    t_dp_stat stat;

    // sequencer
    plt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // store, count, pointer and result registers
    plt_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_position    (i_position),
        .i_value       (i_value),
        .i_ctl         (ctl),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_found_index (o_found_index),
        .o_count       (o_count)
    );

endmodule

// ===== rtl/plt_checker.sv =====
// ============================================================================
// plt_checker
// Port-level checks for the positional list table unit.
// ============================================================================
module plt_checker
    import plt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    o_valid,
    input logic [2:0]              o_status,
    input logic signed [VAL_W-1:0] o_read_value,
    input logic [CNT_W-1:0]        o_count
);

    // result strobe only once the request has finished
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // accepted request makes the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // failed request leaves the list unchanged and returns no data
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_read_value == '0 && o_count == $past(o_count)))
        else $error("failed request changed count or returned data");

    // full is reported only when the list holds DEPTH entries
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_count == CNT_W'(DEPTH)))
        else $error("full status with list not full");

endmodule

bind positional_list_table_unit plt_checker #(.DEPTH(DEPTH)) u_plt_checker (.*);

// ===== sim/positional_list_table_unit_test.sv =====
// ============================================================================
// positional_list_table_unit_test
// Self-checking bench for the positional list table unit. A queue-based
// model of the list predicts status, read value, found index and count for
// every accepted request; each result strobe is checked against the oldest
// prediction. Directed corner cases come first, then random traffic that
// fills, drains and churns the list with bursty request timing.
// ============================================================================
module positional_list_table_unit_test;
    import plt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Unused command codes: the block must treat them as no-ops.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // Longest walk is a full-list delete from the front.
    localparam int DRAIN_CYCLES = DEPTH_DEF + 16;

    typedef struct {
        t_status          status;
        logic [VAL_W-1:0] read_value;
        logic [IDX_W-1:0] found_index;
        logic [CNT_W-1:0] count;
    } t_list_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [CMD_W-1:0]        i_cmd = '0;
    logic [POS_W-1:0]        i_position = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    o_valid;
    logic [2:0]              o_status;
    logic signed [VAL_W-1:0] o_read_value;
    logic [IDX_W-1:0]        o_found_index;
    logic [CNT_W-1:0]        o_count;

    // Model of the list contents: element 0 is list position 1.
    logic signed [VAL_W-1:0] list_words[$];
    // Predicted results, oldest first.
    t_list_result            pending_results[$];
    int                      mismatch_count = 0;
    // Requests left in the current back-to-back burst.
    int                      burst_left = 0;

    positional_list_table_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_found_index (o_found_index),
        .o_count       (o_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // List model: applies one request and returns the result it must produce.
    // Full is checked ahead of position on insert; get on an empty list is a
    // bad position; locate returns the first match only.
    // ------------------------------------------------------------------------
    function automatic t_list_result apply_list_command(logic [CMD_W-1:0] cmd,
                                                        logic [POS_W-1:0] pos,
                                                        logic signed [VAL_W-1:0] val);
        t_list_result r;
        int           used;
        int           p;
        used = list_words.size();
        p    = int'(pos);
        r.status      = ST_OK;
        r.read_value  = '0;
        r.found_index = '0;
        case (cmd)
            CMD_CLEAR: begin
                list_words.delete();
            end
            CMD_INSERT: begin
                if (used >= DEPTH_DEF)
                    r.status = ST_FULL;
                else if (p < 1 || p > used + 1)
                    r.status = ST_BADPOS;
                else
                    list_words.insert(p - 1, val);
            end
            CMD_DELETE: begin
                if (used == 0)
                    r.status = ST_EMPTY;
                else if (p < 1 || p > used)
                    r.status = ST_BADPOS;
                else begin
                    r.read_value = list_words[p - 1];
                    list_words.delete(p - 1);
                end
            end
            CMD_GET: begin
                if (p < 1 || p > used)
                    r.status = ST_BADPOS;
                else
                    r.read_value = list_words[p - 1];
            end
            CMD_LOCATE: begin
                r.status = ST_NOTFOUND;
                for (int k = 0; k < used; k++) begin
                    if (list_words[k] == val) begin
                        r.status      = ST_OK;
                        r.found_index = IDX_W'(k);
                        break;
                    end
                end
            end
            default: begin
                // spare codes: nothing changes
            end
        endcase
        r.count = CNT_W'(list_words.size());
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Requests go out in bursts; between bursts start drops
    // for a random number of cycles so the next request lands at an arbitrary
    // point of the previous walk. start is never dropped and raised in the
    // same step.
    // ------------------------------------------------------------------------
    task automatic issue_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                 logic signed [VAL_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 80) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_position <= pos;
        i_value    <= val;
        // accepted at the first edge where busy is low
        do @(posedge i_clk); while (busy);
        burst_left--;
        pending_results.push_back(apply_list_command(cmd, pos, val));
    endtask

    // ------------------------------------------------------------------------
    // Result checker. The receiver cannot stall, so every strobe is consumed.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result strobe with no request outstanding");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("o_status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_read_value !== want.read_value) begin
                    $error("o_read_value: expected %0d, got %0d",
                           $signed(want.read_value), o_read_value);
                    mismatch_count++;
                end
                if (o_found_index !== want.found_index) begin
                    $error("o_found_index: expected %0d, got %0d",
                           want.found_index, o_found_index);
                    mismatch_count++;
                end
                if (o_count !== want.count) begin
                    $error("o_count: expected %0d, got %0d", want.count, o_count);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Random field helpers.
    // ------------------------------------------------------------------------
    // Mix of full-range words, extremes and a narrow band that makes
    // duplicates likely, so locate has to pick the first match.
    function automatic logic signed [VAL_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return '0;
                    default: return -32'sd1;
                endcase
            end
            default: return $signed($urandom_range(0, 15)) - 32'sd8;
        endcase
    endfunction

    // Mostly legal positions up to limit; some zero, one past, any 7-bit code.
    function automatic logic [POS_W-1:0] pick_position(int limit);
        case ($urandom_range(0, 19))
            0: return '0;
            1: return POS_W'(limit + 1);
            2: return POS_W'($urandom_range(0, 127));
            default: return (limit < 1) ? POS_W'(1) : POS_W'($urandom_range(1, limit));
        endcase
    endfunction

    // Locate key: usually something in the list, sometimes anything.
    function automatic logic signed [VAL_W-1:0] locate_key();
        if (list_words.size() != 0 && $urandom_range(0, 3) != 0)
            return list_words[$urandom_range(0, list_words.size() - 1)];
        return rand_word();
    endfunction

    // One random request. ins_pct/del_pct steer list growth; with_rare
    // mixes in clears and spare codes.
    task automatic random_request(int ins_pct, int del_pct, bit with_rare);
        int roll;
        int used;
        roll = $urandom_range(0, 99);
        used = list_words.size();
        if (roll < ins_pct)
            issue_request(CMD_INSERT, pick_position(used + 1), rand_word());
        else if (roll < ins_pct + del_pct)
            issue_request(CMD_DELETE, pick_position(used), rand_word());
        else if (with_rare && roll == 99)
            issue_request(CMD_CLEAR, POS_W'($urandom), rand_word());
        else if (with_rare && roll == 98)
            issue_request(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                          POS_W'($urandom), rand_word());
        else if ($urandom_range(0, 1) == 0)
            issue_request(CMD_GET, pick_position(used), rand_word());
        else
            issue_request(CMD_LOCATE, POS_W'($urandom), locate_key());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Empty-list errors, bad positions, front/middle/append inserts, first
    // and last entry access, duplicate keys and the spare command codes.
    task automatic test_directed();
        issue_request(CMD_CLEAR, 7'd0, 32'sd0);
        issue_request(CMD_GET, 7'd1, 32'sd0);
        issue_request(CMD_DELETE, 7'd1, 32'sd0);
        issue_request(CMD_LOCATE, 7'd0, 32'sd0);
        issue_request(CMD_INSERT, 7'd0, 32'sd9);
        issue_request(CMD_INSERT, 7'd2, 32'sd9);
        issue_request(CMD_INSERT, 7'd1, 32'sh7FFF_FFFF);
        issue_request(CMD_INSERT, 7'd2, 32'sh8000_0000);   // append
        issue_request(CMD_INSERT, 7'd1, -32'sd1);          // front
        issue_request(CMD_INSERT, 7'd2, 32'sd0);           // middle
        issue_request(CMD_INSERT, 7'd5, 32'sd5);           // append
        issue_request(CMD_GET, 7'd1, 32'sd0);
        issue_request(CMD_GET, 7'd5, 32'sd0);
        issue_request(CMD_GET, 7'd6, 32'sd0);
        issue_request(CMD_GET, 7'd0, 32'sd0);
        issue_request(CMD_GET, 7'h7F, 32'sd0);
        issue_request(CMD_LOCATE, 7'd0, 32'sd5);           // last entry
        issue_request(CMD_LOCATE, 7'd0, 32'sh8000_0000);
        issue_request(CMD_LOCATE, 7'd0, 32'sd1234);
        issue_request(CMD_INSERT, 7'd2, -32'sd1);          // duplicate key
        issue_request(CMD_LOCATE, 7'h7F, -32'sd1);         // first match wins
        issue_request(CMD_DELETE, 7'd6, 32'sd0);           // last
        issue_request(CMD_DELETE, 7'd1, 32'sd0);           // first
        issue_request(CMD_DELETE, 7'd0, 32'sd0);
        issue_request(CMD_DELETE, 7'h7F, -32'sd1);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            issue_request(CMD_W'(c), 7'h7F, -32'sd1);
        issue_request(CMD_CLEAR, 7'h7F, -32'sd1);
    endtask

    // Insert-heavy: grows to DEPTH and keeps hitting the full check.
    task automatic test_fill_to_full();
        repeat (250) random_request(70, 10, 1'b0);
    endtask

    // Delete-heavy: walks back down to empty and probes the empty check.
    task automatic test_drain();
        repeat (250) random_request(10, 65, 1'b0);
    endtask

    // Balanced churn with clears and spare codes sprinkled in.
    task automatic test_mixed_traffic();
        repeat (900) random_request(36, 30, 1'b1);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_to_full();
        test_drain();
        test_mixed_traffic();

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // let any stray strobe show up before calling it
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: slowest legal run (longest walk plus longest gap on every
    // request) is under 3 ms.
    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

endmodule
